// ===== rtl/core/msw_pkg.sv =====
package msw_pkg;

  // Configuration port
  localparam int CFG_BITS       = 16;
  localparam int CFG_INDEX_BITS = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PAN     = 2'd0,
    REG_WIDTH   = 2'd1,
    REG_BALANCE = 2'd2
  } msw_reg_t;

  // Fixed-point formats
  localparam int GAIN_BITS  = 16;   // Q15 gains and Q14 width, all within [0, 32768]
  localparam int PHASE_BITS = 17;   // quarter-wave phase in [0, 65536]
  localparam int FRAC_BITS  = 16;   // interpolation fraction
  localparam int SHIFT_MID  = 14;   // mid path is aligned to the width scale
  localparam int SHIFT_ACC  = 15;   // accumulator drop before the pan gain
  localparam int SHIFT_OUT  = 30;   // final scale of the pan product

  // Pipeline depth: entry stage plus six processing stages
  localparam int NUM_STAGES = 7;

  // Sine table construction: pi/2 in Q30 and the Taylor series divisors
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SERIES_DIV [1:7] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
  };

  // Per-stage advance enables handed to the datapath modules
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
    logic s7;
  } msw_adv_t;

endpackage

// ===== rtl/core/msw_if.sv =====
interface msw_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic signed [16:0]            pan_offset;
  logic signed [15:0]            width_offset;
  logic                          frame_last;

  modport source (
    output valid, left_in, right_in, pan_offset, width_offset, frame_last,
    input  ready
  );
  modport sink (
    input  valid, left_in, right_in, pan_offset, width_offset, frame_last,
    output ready
  );
endinterface

interface msw_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          frame_last_out;

  modport source (
    output valid, left_out, right_out, frame_last_out,
    input  ready
  );
  modport sink (
    input  valid, left_out, right_out, frame_last_out,
    output ready
  );
endinterface

// ===== rtl/core/msw_lut.sv =====
module msw_lut import msw_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                  clk,
  input  msw_adv_t              adv,
  input  logic [PHASE_BITS-1:0] phase,
  output logic [GAIN_BITS-1:0]  gain_left,
  output logic [GAIN_BITS-1:0]  gain_right
);

  localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW = FRAC_BITS + IW;

  // Build one Q15 entry sin(k/D * pi/2) with integer series arithmetic
  function automatic logic [GAIN_BITS-1:0] sine_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic [63:0]        q;
    x    = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    acc  = $signed(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x2) >> 30;
      term = term / SERIES_DIV[n];
      if (n % 2 == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = '0;
    end
    q = ($unsigned(acc) + 64'd16384) >> 15;
    if (q > 64'd32768) begin
      q = 64'd32768;
    end
    return q[GAIN_BITS-1:0];
  endfunction

  logic [GAIN_BITS-1:0] rom [0:SINE_TABLE_DEPTH];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    assign rom[k] = sine_entry(k);
  end

  // Lane 0 is the right gain (sine), lane 1 the left gain (cosine)
  logic [PHASE_BITS-1:0] lane_phase [2];
  logic [PW-1:0]         pos        [2];
  logic [IW-1:0]         idx_next   [2];
  logic [GAIN_BITS-1:0]  delta      [2];

  logic [IW-1:0]          idx2   [2];
  logic [FRAC_BITS-1:0]   frac2  [2];
  logic [GAIN_BITS-1:0]   lo3    [2];
  logic [GAIN_BITS-1:0]   hi3    [2];
  logic [FRAC_BITS-1:0]   frac3  [2];
  logic [GAIN_BITS-1:0]   base4  [2];
  logic [31:0]            prod4  [2];
  logic [GAIN_BITS-1:0]   gain5  [2];

  // Table position, neighbor index and neighbor step per lane
  always_comb begin
    lane_phase[0] = phase;
    lane_phase[1] = PHASE_BITS'(18'h10000 - 18'(phase));
    for (int i = 0; i < 2; i++) begin
      pos[i] = PW'(lane_phase[i]) * PW'(SINE_TABLE_DEPTH);
      if (idx2[i] >= IW'(SINE_TABLE_DEPTH)) begin
        idx_next[i] = IW'(SINE_TABLE_DEPTH);
      end else begin
        idx_next[i] = idx2[i] + 1'b1;
      end
      if (hi3[i] >= lo3[i]) begin
        delta[i] = hi3[i] - lo3[i];
      end else begin
        delta[i] = '0;
      end
    end
  end

  // Split position, read neighbors, scale the step, round and add
  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      if (adv.s2) begin
        idx2[i]  <= pos[i][PW-1:FRAC_BITS];
        frac2[i] <= pos[i][FRAC_BITS-1:0];
      end
      if (adv.s3) begin
        lo3[i]   <= rom[idx2[i]];
        hi3[i]   <= rom[idx_next[i]];
        frac3[i] <= frac2[i];
      end
      if (adv.s4) begin
        base4[i] <= lo3[i];
        prod4[i] <= 32'(delta[i]) * 32'(frac3[i]);
      end
      if (adv.s5) begin
        gain5[i] <= base4[i] + GAIN_BITS'((prod4[i] + 32'h8000) >> FRAC_BITS);
      end
    end
  end

  assign gain_right = gain5[0];
  assign gain_left  = gain5[1];

endmodule

// ===== rtl/core/msw_mix.sv =====
module msw_mix import msw_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                           clk,
  input  msw_adv_t                       adv,
  input  logic signed [SAMPLE_BITS:0]    lr_sum,
  input  logic signed [SAMPLE_BITS:0]    lr_diff,
  input  logic [GAIN_BITS-1:0]           center_gain,
  input  logic [GAIN_BITS-1:0]           spread_gain,
  input  logic [GAIN_BITS-1:0]           width,
  output logic signed [SAMPLE_BITS+16:0] acc_left,
  output logic signed [SAMPLE_BITS+16:0] acc_right
);

  localparam int MW = SAMPLE_BITS + 17;   // mid product
  localparam int AW = SAMPLE_BITS + 32;   // accumulator at scale 2^30
  localparam int BW = SAMPLE_BITS + 17;   // accumulator after the drop
  localparam int SW = 2 * GAIN_BITS - 1;  // side gain times width

  logic signed [MW-1:0]          mid2;
  logic [SW-1:0]                 sw2;
  logic signed [SAMPLE_BITS:0]   diff2;
  logic signed [MW-1:0]          mid3;
  logic signed [AW-1:0]          side3;
  logic signed [AW-1:0]          mid_ext;
  logic signed [AW-1:0]          acc_l4;
  logic signed [AW-1:0]          acc_r4;
  logic signed [BW-1:0]          acc_l5;
  logic signed [BW-1:0]          acc_r5;

  assign mid_ext = AW'(mid3) <<< SHIFT_MID;

  // Gain mid and side, combine, drop to the pan-gain scale
  always_ff @(posedge clk) begin
    if (adv.s2) begin
      mid2  <= MW'(lr_sum * $signed({1'b0, center_gain}));
      sw2   <= SW'(spread_gain * width);
      diff2 <= lr_diff;
    end
    if (adv.s3) begin
      mid3  <= mid2;
      side3 <= AW'(diff2 * $signed({1'b0, sw2}));
    end
    if (adv.s4) begin
      acc_l4 <= mid_ext + side3;
      acc_r4 <= mid_ext - side3;
    end
    if (adv.s5) begin
      acc_l5 <= BW'(acc_l4 >>> SHIFT_ACC);
      acc_r5 <= BW'(acc_r4 >>> SHIFT_ACC);
    end
  end

  assign acc_left  = acc_l5;
  assign acc_right = acc_r5;

endmodule

// ===== rtl/core/msw_out.sv =====
module msw_out import msw_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                           clk,
  input  msw_adv_t                       adv,
  input  logic signed [SAMPLE_BITS+16:0] acc_left,
  input  logic signed [SAMPLE_BITS+16:0] acc_right,
  input  logic [GAIN_BITS-1:0]           gain_left,
  input  logic [GAIN_BITS-1:0]           gain_right,
  output logic signed [SAMPLE_BITS-1:0]  left_out,
  output logic signed [SAMPLE_BITS-1:0]  right_out
);

  localparam int BW  = SAMPLE_BITS + 17;
  localparam int PRW = SAMPLE_BITS + 34;
  localparam int YW  = SAMPLE_BITS + 4;
  localparam logic signed [YW-1:0]  SAT_HI = YW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [YW-1:0]  SAT_LO = -SAT_HI - YW'(1);
  localparam logic signed [PRW-1:0] ROUND_HALF = PRW'(64'sd1 <<< (SHIFT_OUT - 1));

  logic signed [BW-1:0]          acc   [2];
  logic [GAIN_BITS-1:0]          gain  [2];
  logic signed [PRW-1:0]         prod6 [2];
  logic signed [PRW-1:0]         rnd   [2];
  logic signed [YW-1:0]          y     [2];
  logic signed [SAMPLE_BITS-1:0] sat   [2];
  logic signed [SAMPLE_BITS-1:0] out7  [2];

  // Round half up, then clip to the sample range
  always_comb begin
    acc[0]  = acc_left;
    acc[1]  = acc_right;
    gain[0] = gain_left;
    gain[1] = gain_right;
    for (int i = 0; i < 2; i++) begin
      rnd[i] = prod6[i] + ROUND_HALF;
      y[i]   = YW'(rnd[i] >>> SHIFT_OUT);
      if (y[i] > SAT_HI) begin
        sat[i] = SAT_HI[SAMPLE_BITS-1:0];
      end else if (y[i] < SAT_LO) begin
        sat[i] = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
        sat[i] = y[i][SAMPLE_BITS-1:0];
      end
    end
  end

  // Apply pan gain, then hold the result in the output register
  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      if (adv.s6) begin
        prod6[i] <= PRW'(acc[i] * $signed({1'b0, gain[i]}));
      end
      if (adv.s7) begin
        out7[i] <= sat[i];
      end
    end
  end

  assign left_out  = out7[0];
  assign right_out = out7[1];

endmodule

// ===== rtl/core/stereo_mid_side_width_pan.sv =====
// An accepted request passes every stage register on its way to result_ch.
// Throughput: one frame per cycle while the sink is ready; every stage has its own
// valid bit, advances when the stage after it is empty or moving; bubbles close up.
// Reset (rst, synchronous): clears all valid bits and restores pan 0, width 1.0
// and balance 0.5. The sine table is a constant built at elaboration.
module stereo_mid_side_width_pan import msw_pkg::*; #(
  parameter int SAMPLE_BITS      = 24,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_wdata,
  msw_in_if.sink                    sample_ch,
  msw_out_if.source                 result_ch
);

  logic signed [15:0] pan_setting;
  logic [15:0]        width_setting;
  logic [15:0]        mid_side_balance;

  logic [NUM_STAGES:1]   v;
  logic [NUM_STAGES+1:1] en;
  logic [NUM_STAGES:1]   last_pipe;
  msw_adv_t              adv;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      pan_setting      <= '0;
      width_setting    <= 16'd16384;
      mid_side_balance <= 16'd16384;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PAN:     pan_setting      <= $signed(cfg_wdata);
        REG_WIDTH:   width_setting    <= cfg_wdata;
        REG_BALANCE: mid_side_balance <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage moves when it is empty or its successor moves
  always_comb begin
    en[NUM_STAGES+1] = result_ch.ready;
    for (int k = NUM_STAGES; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign adv = '{s2: en[2], s3: en[3], s4: en[4], s5: en[5], s6: en[6], s7: en[7]};
  assign sample_ch.ready = en[1];

  // Advance valid bits and the last-frame marker
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= sample_ch.valid;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      last_pipe[1] <= sample_ch.frame_last;
    end
    for (int k = 2; k <= NUM_STAGES; k++) begin
      if (en[k]) begin
        last_pipe[k] <= last_pipe[k-1];
      end
    end
  end

  // Entry stage: clamp controls, derive gains, split into sum and difference
  logic signed [17:0]          pan_phase;
  logic signed [17:0]          width_sum;
  logic [16:0]                 bal_rest;
  logic [PHASE_BITS-1:0]       phase_c;
  logic [GAIN_BITS-1:0]        width_c;
  logic [GAIN_BITS-1:0]        center_gain_c;
  logic [GAIN_BITS-1:0]        spread_gain_c;

  always_comb begin
    pan_phase = {{2{pan_setting[15]}}, pan_setting}
              + {sample_ch.pan_offset[16], sample_ch.pan_offset}
              + 18'sd32768;
    if (pan_phase < 18'sd0) begin
      phase_c = '0;
    end else if (pan_phase > 18'sd65536) begin
      phase_c = PHASE_BITS'(65536);
    end else begin
      phase_c = pan_phase[PHASE_BITS-1:0];
    end

    width_sum = {2'b00, width_setting}
              + {{2{sample_ch.width_offset[15]}}, sample_ch.width_offset};
    if (width_sum < 18'sd0) begin
      width_c = '0;
    end else if (width_sum > 18'sd32768) begin
      width_c = GAIN_BITS'(32768);
    end else begin
      width_c = width_sum[GAIN_BITS-1:0];
    end

    bal_rest = 17'd32768 - {1'b0, mid_side_balance};
    if (mid_side_balance >= 16'd32768) begin
      center_gain_c = '0;
    end else if (mid_side_balance <= 16'd16384) begin
      center_gain_c = GAIN_BITS'(32768);
    end else begin
      center_gain_c = {bal_rest[14:0], 1'b0};
    end

    if (mid_side_balance >= 16'd16384) begin
      spread_gain_c = GAIN_BITS'(32768);
    end else begin
      spread_gain_c = {mid_side_balance[14:0], 1'b0};
    end
  end

  logic signed [SAMPLE_BITS:0] lr_sum1;
  logic signed [SAMPLE_BITS:0] lr_diff1;
  logic [PHASE_BITS-1:0]       phase1;
  logic [GAIN_BITS-1:0]        width1;
  logic [GAIN_BITS-1:0]        center_gain1;
  logic [GAIN_BITS-1:0]        spread_gain1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      lr_sum1      <= {sample_ch.left_in[SAMPLE_BITS-1], sample_ch.left_in}
                    + {sample_ch.right_in[SAMPLE_BITS-1], sample_ch.right_in};
      lr_diff1     <= {sample_ch.left_in[SAMPLE_BITS-1], sample_ch.left_in}
                    - {sample_ch.right_in[SAMPLE_BITS-1], sample_ch.right_in};
      phase1       <= phase_c;
      width1       <= width_c;
      center_gain1 <= center_gain_c;
      spread_gain1 <= spread_gain_c;
    end
  end

  logic [GAIN_BITS-1:0]           gain_left;
  logic [GAIN_BITS-1:0]           gain_right;
  logic signed [SAMPLE_BITS+16:0] acc_left;
  logic signed [SAMPLE_BITS+16:0] acc_right;

  msw_lut #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_lut (
    .clk        (clk),
    .adv        (adv),
    .phase      (phase1),
    .gain_left  (gain_left),
    .gain_right (gain_right)
  );

  msw_mix #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mix (
    .clk         (clk),
    .adv         (adv),
    .lr_sum      (lr_sum1),
    .lr_diff     (lr_diff1),
    .center_gain (center_gain1),
    .spread_gain (spread_gain1),
    .width       (width1),
    .acc_left    (acc_left),
    .acc_right   (acc_right)
  );

  msw_out #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_out (
    .clk        (clk),
    .adv        (adv),
    .acc_left   (acc_left),
    .acc_right  (acc_right),
    .gain_left  (gain_left),
    .gain_right (gain_right),
    .left_out   (result_ch.left_out),
    .right_out  (result_ch.right_out)
  );

  assign result_ch.valid          = v[NUM_STAGES];
  assign result_ch.frame_last_out = last_pipe[NUM_STAGES];

`ifndef NO_ASSERTIONS
  // Nothing leaves the pipe right after reset
  assert property (@(posedge clk) $past(rst) |-> !result_ch.valid)
    else $error("result valid right after reset");

  // Requests are refused only when every stage is full and the sink stalls
  assert property (@(posedge clk) disable iff (rst)
    !sample_ch.ready |-> (&v && !result_ch.ready))
    else $error("request refused while the pipe has room");

  // A frame in the stage before the output register reaches the output when the sink was ready
  assert property (@(posedge clk) disable iff (rst)
    ($past(result_ch.ready) && $past(v[NUM_STAGES-1]) && !$past(rst)) |-> result_ch.valid)
    else $error("frame lost before the output register");
`endif

endmodule
